@@ rtl/assert_macros.svh @@
// Assertion helpers used by vec4_normalize_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold on every clock while out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("%m: %s failed", "label");

// ante implies cons on the same clock
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: %s failed", "label");

`endif

@@ rtl/vnrm_pkg.sv @@
package vnrm_pkg;

	localparam int COMP_W    = 16;
	localparam int FRAC_W    = 14;
	localparam int UNIT_W    = FRAC_W + 2;
	localparam int MAG_W     = COMP_W + 1;
	localparam int SQ_W      = 2 * COMP_W - 1;
	localparam int SUM_W     = SQ_W + 2;
	localparam int REM_W     = SUM_W + 1;
	localparam int QUO_W     = 2 * FRAC_W + 1;
	localparam int DIV_STEPS = QUO_W;
	localparam int LANES     = 4;
	localparam int RAD_W     = 34;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int SREM_W    = ROOT_W + 2;
	localparam int SQ_STEPS  = ROOT_W;
	localparam int SQ_LANES  = LANES + 1;

	typedef struct packed {
		logic                         valid;
		logic                         zero;
		logic [LANES-1:0]             neg;
		logic [SUM_W-1:0]             sum;
		logic [LANES-1:0][REM_W-1:0]  rem;
		logic [LANES-1:0][QUO_W-1:0]  quo;
	} div_word_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_lane_t;

	typedef struct packed {
		logic                           valid;
		logic                           zero;
		logic [LANES-1:0]               neg;
		logic [SQ_LANES-1:0][$bits(sq_lane_t)-1:0] lane;
	} sq_word_t;

	// one digit of the shift-subtract square root, two radicand bits in
	function automatic sq_lane_t sqrt_step(sq_lane_t a);
		logic [SREM_W+1:0] ext;
		logic [SREM_W+1:0] trial;
		sq_lane_t r;
		ext = {a.rem, a.rad[RAD_W-1 -: 2]};
		trial = {2'b00, a.root, 2'b01};
		r.rad = {a.rad[RAD_W-3:0], 2'b00};
		if (ext >= trial) begin
			r.rem = SREM_W'(ext - trial);
			r.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem = ext[SREM_W-1:0];
			r.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

@@ rtl/vnrm_div_cell.sv @@
// One quotient bit of |c|^2 * 2^28 / S for every lane.
module vnrm_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  vnrm_pkg::div_word_t  d_in,
	output vnrm_pkg::div_word_t  d_out
);

	vnrm_pkg::div_word_t nxt;
	vnrm_pkg::div_word_t word_q;
	logic                valid_q;

	always_comb begin
		logic                           ge;
		logic [vnrm_pkg::REM_W-1:0]     diff;
		nxt = d_in;
		for (int i = 0; i < vnrm_pkg::LANES; i++) begin
			ge = d_in.rem[i] >= {1'b0, d_in.sum};
			diff = ge ? d_in.rem[i] - {1'b0, d_in.sum} : d_in.rem[i];
			nxt.rem[i] = {diff[vnrm_pkg::REM_W-2:0], 1'b0};
			nxt.quo[i] = {d_in.quo[i][vnrm_pkg::QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= nxt;
		end
	end

	always_comb begin
		d_out = word_q;
		d_out.valid = valid_q;
	end

endmodule

@@ rtl/vnrm_sqrt_cell.sv @@
// One root digit for each of the four unit lanes and the length lane.
module vnrm_sqrt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  vnrm_pkg::sq_word_t  s_in,
	output vnrm_pkg::sq_word_t  s_out
);

	vnrm_pkg::sq_word_t nxt;
	vnrm_pkg::sq_word_t word_q;
	logic               valid_q;

	always_comb begin
		nxt = s_in;
		for (int i = 0; i < vnrm_pkg::SQ_LANES; i++) begin
			nxt.lane[i] = vnrm_pkg::sqrt_step(vnrm_pkg::sq_lane_t'(s_in.lane[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= s_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= nxt;
		end
	end

	always_comb begin
		s_out = word_q;
		s_out.valid = valid_q;
	end

endmodule

@@ rtl/vec4_normalize_core.sv @@
// Four-component vector normalizer. Every unstalled cycle it takes one vector
// of signed Q8.8 components and, after the square, sum, divide, root and
// output registers, returns the length (unsigned Q9.8, rounded down) and the
// four unit components (signed Q1.14, rounded toward zero). Squaring and
// summing take two stages, a row of 29 divide cells yields one quotient bit
// each of c^2/S, and a row of 17 root cells yields one root bit each for the
// four units and the length. The whole row moves together, so a stall on the
// result side stalls the input the same cycle. An all-zero vector sets
// zero_vector with zero length and zero units.
`include "assert_macros.svh"

module vec4_normalize_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [vnrm_pkg::COMP_W-1:0] comp_x,
	input  logic signed [vnrm_pkg::COMP_W-1:0] comp_y,
	input  logic signed [vnrm_pkg::COMP_W-1:0] comp_z,
	input  logic signed [vnrm_pkg::COMP_W-1:0] comp_w,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [vnrm_pkg::UNIT_W-1:0] unit_x,
	output logic signed [vnrm_pkg::UNIT_W-1:0] unit_y,
	output logic signed [vnrm_pkg::UNIT_W-1:0] unit_z,
	output logic signed [vnrm_pkg::UNIT_W-1:0] unit_w,
	output logic [vnrm_pkg::MAG_W-1:0]    magnitude,
	output logic                          zero_vector
);

	localparam int L = vnrm_pkg::LANES;

	logic en;
	logic out_valid_q;

	logic signed [L-1:0][vnrm_pkg::COMP_W-1:0] comp;
	logic [L-1:0][vnrm_pkg::SQ_W-1:0]          sq_s1;
	logic [L-1:0]                              neg_s1;
	logic                                      valid_s1;
	logic [L-1:0][vnrm_pkg::SQ_W-1:0]          sq_s2;
	logic [L-1:0]                              neg_s2;
	logic [vnrm_pkg::SUM_W-1:0]                sum_s2;
	logic                                      valid_s2;

	vnrm_pkg::div_word_t dw [0:vnrm_pkg::DIV_STEPS];
	vnrm_pkg::sq_word_t  sw [0:vnrm_pkg::SQ_STEPS];

	logic [L-1:0][vnrm_pkg::UNIT_W-1:0] unit_q;
	logic [vnrm_pkg::MAG_W-1:0]         mag_q;
	logic                               zero_q;

	assign en = !(out_valid_q && out_stall);
	assign in_stall = !en;
	assign comp = {comp_w, comp_z, comp_y, comp_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			out_valid_q <= sw[vnrm_pkg::SQ_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		logic [vnrm_pkg::COMP_W:0] m;
		logic [2*vnrm_pkg::COMP_W+1:0] p;
		if (en) begin
			for (int i = 0; i < L; i++) begin
				m = comp[i][vnrm_pkg::COMP_W-1] ? -{comp[i][vnrm_pkg::COMP_W-1], comp[i]}
				                                : {1'b0, comp[i]};
				p = m * m;
				sq_s1[i] <= p[vnrm_pkg::SQ_W-1:0];
				neg_s1[i] <= comp[i][vnrm_pkg::COMP_W-1];
			end
			sq_s2 <= sq_s1;
			neg_s2 <= neg_s1;
			sum_s2 <= ({2'b0, sq_s1[0]} + {2'b0, sq_s1[1]})
			        + ({2'b0, sq_s1[2]} + {2'b0, sq_s1[3]});
		end
	end

	always_comb begin
		dw[0].valid = valid_s2;
		dw[0].zero = (sum_s2 == '0);
		dw[0].neg = neg_s2;
		dw[0].sum = sum_s2;
		for (int i = 0; i < L; i++) begin
			dw[0].rem[i] = {{(vnrm_pkg::REM_W-vnrm_pkg::SQ_W){1'b0}}, sq_s2[i]};
			dw[0].quo[i] = '0;
		end
	end

	for (genvar g = 0; g < vnrm_pkg::DIV_STEPS; g++) begin : g_div
		vnrm_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_in   (dw[g]),
			.d_out  (dw[g+1])
		);
	end

	always_comb begin
		vnrm_pkg::sq_lane_t ln;
		sw[0].valid = dw[vnrm_pkg::DIV_STEPS].valid;
		sw[0].zero = dw[vnrm_pkg::DIV_STEPS].zero;
		sw[0].neg = dw[vnrm_pkg::DIV_STEPS].neg;
		for (int i = 0; i < L; i++) begin
			ln.rad = {{(vnrm_pkg::RAD_W-vnrm_pkg::QUO_W){1'b0}},
			          dw[vnrm_pkg::DIV_STEPS].quo[i]};
			ln.rem = '0;
			ln.root = '0;
			sw[0].lane[i] = ln;
		end
		ln.rad = {{(vnrm_pkg::RAD_W-vnrm_pkg::SUM_W){1'b0}}, dw[vnrm_pkg::DIV_STEPS].sum};
		ln.rem = '0;
		ln.root = '0;
		sw[0].lane[L] = ln;
	end

	for (genvar g = 0; g < vnrm_pkg::SQ_STEPS; g++) begin : g_sqrt
		vnrm_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.s_in   (sw[g]),
			.s_out  (sw[g+1])
		);
	end

	always_ff @(posedge clk) begin
		vnrm_pkg::sq_lane_t ln;
		logic [vnrm_pkg::UNIT_W-1:0] r;
		if (en) begin
			for (int i = 0; i < L; i++) begin
				ln = vnrm_pkg::sq_lane_t'(sw[vnrm_pkg::SQ_STEPS].lane[i]);
				r = ln.root[vnrm_pkg::UNIT_W-1:0];
				if (sw[vnrm_pkg::SQ_STEPS].zero) begin
					unit_q[i] <= '0;
				end else begin
					unit_q[i] <= sw[vnrm_pkg::SQ_STEPS].neg[i] ? -r : r;
				end
			end
			ln = vnrm_pkg::sq_lane_t'(sw[vnrm_pkg::SQ_STEPS].lane[L]);
			mag_q <= ln.root[vnrm_pkg::MAG_W-1:0];
			zero_q <= sw[vnrm_pkg::SQ_STEPS].zero;
		end
	end

	assign out_valid = out_valid_q;
	assign unit_x = unit_q[0];
	assign unit_y = unit_q[1];
	assign unit_z = unit_q[2];
	assign unit_w = unit_q[3];
	assign magnitude = mag_q;
	assign zero_vector = zero_q;

	`ASSERT_IMPLIES(a_zero_word, clk, arst_n, out_valid && zero_vector, magnitude == '0 && unit_x == '0 && unit_y == '0 && unit_z == '0 && unit_w == '0)
	`ASSERT_IMPLIES(a_len_nonzero, clk, arst_n, out_valid && !zero_vector, magnitude != '0)
	`ASSERT_IMPLIES(a_unit_range, clk, arst_n, out_valid, $signed(unit_x) <= 16384 && $signed(unit_x) >= -16384 && $signed(unit_w) <= 16384 && $signed(unit_w) >= -16384)
	`ASSERT_ALWAYS(a_stall_link, clk, arst_n, in_stall == (out_valid && out_stall))

endmodule

@@ tb/sv/tb_vec4_normalize_core.sv @@
`timescale 1ns / 1ps

module tb_vec4_normalize_core;

	typedef struct {
		logic signed [vnrm_pkg::UNIT_W-1:0] ux, uy, uz, uw;
		logic [vnrm_pkg::MAG_W-1:0] mag;
		logic zero;
	} unit_word_t;

	class norm_scoreboard;
		unit_word_t pending[$];
		int errors = 0;

		function automatic longint unsigned root_floor(longint unsigned s);
			longint unsigned r, t;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= s) r = t;
			end
			return r;
		endfunction

		function automatic void note_vector(logic signed [vnrm_pkg::COMP_W-1:0] c [4]);
			longint unsigned m [4];
			longint unsigned sum, q;
			logic signed [vnrm_pkg::UNIT_W-1:0] u [4];
			unit_word_t e;
			sum = 0;
			for (int i = 0; i < 4; i++) begin
				m[i] = c[i] < 0 ? longint'(-longint'(c[i])) : longint'(c[i]);
				sum += m[i] * m[i];
			end
			for (int i = 0; i < 4; i++) begin
				if (sum == 0) u[i] = '0;
				else begin
					// exact: floor(sqrt(floor(c^2 * 2^28 / S)))
					q = root_floor(((m[i] * m[i]) << (2 * vnrm_pkg::FRAC_W)) / sum);
					u[i] = c[i] < 0 ? vnrm_pkg::UNIT_W'(-q) : vnrm_pkg::UNIT_W'(q);
				end
			end
			e.ux = u[0]; e.uy = u[1]; e.uz = u[2]; e.uw = u[3];
			e.mag = vnrm_pkg::MAG_W'(root_floor(sum));
			e.zero = (sum == 0);
			pending.push_back(e);
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			if (errors <= 30) $display("mismatch %s: got %0d want %0d", what, got, want);
		endtask

		task check_unit(unit_word_t g);
			unit_word_t e;
			if (pending.size() == 0) begin
				report("unexpected word", 0, 0);
				return;
			end
			e = pending.pop_front();
			if (g.ux !== e.ux) report("unit_x", g.ux, e.ux);
			if (g.uy !== e.uy) report("unit_y", g.uy, e.uy);
			if (g.uz !== e.uz) report("unit_z", g.uz, e.uz);
			if (g.uw !== e.uw) report("unit_w", g.uw, e.uw);
			if (g.mag !== e.mag) report("magnitude", g.mag, e.mag);
			if (g.zero !== e.zero) report("zero_vector", g.zero, e.zero);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0;
	logic signed [vnrm_pkg::COMP_W-1:0] comp_x = 0, comp_y = 0, comp_z = 0, comp_w = 0;
	logic in_stall, out_valid, zero_vector;
	logic signed [vnrm_pkg::UNIT_W-1:0] unit_x, unit_y, unit_z, unit_w;
	logic [vnrm_pkg::MAG_W-1:0] magnitude;

	norm_scoreboard sb = new();
	int sent = 0;
	int quiet = 0;

	always #10 clk = ~clk;

	vec4_normalize_core dut (.*);

	// monitors: sample pre-edge values
	always @(posedge clk) begin
		logic signed [vnrm_pkg::COMP_W-1:0] c [4];
		unit_word_t g;
		if (arst_n) begin
			quiet++;
			if (in_valid && !in_stall) begin
				c = '{comp_x, comp_y, comp_z, comp_w};
				sb.note_vector(c);
				quiet = 0;
			end
			if (out_valid && !out_stall) begin
				g.ux = unit_x; g.uy = unit_y; g.uz = unit_z; g.uw = unit_w;
				g.mag = magnitude; g.zero = zero_vector;
				sb.check_unit(g);
				quiet = 0;
			end
			if (quiet >= 3000) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic logic signed [vnrm_pkg::COMP_W-1:0] pick_comp(int kind);
		case (kind)
			0: return vnrm_pkg::COMP_W'($urandom);
			1: return vnrm_pkg::COMP_W'($urandom_range(16)) - 8;
			2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return 0;
		endcase
	endfunction

	task send_vector(logic signed [vnrm_pkg::COMP_W-1:0] x, y, z, w, bit calm);
		in_valid <= 1;
		comp_x <= x; comp_y <= y; comp_z <= z; comp_w <= w;
		do @(posedge clk); while (in_stall);
		sent++;
		// each following cycle idles with the same odds
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 0;
			@(posedge clk);
		end
	endtask

	// receiver: random stalls, one long hold-off, one calm stretch
	initial begin
		int hold;
		bit held;
		hold = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (!held && sent >= 200) begin
				held = 1;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1;
			end else if (sent >= 600 && sent < 900) out_stall <= 0;
			else out_stall <= ($urandom_range(99) < 37);
		end
	end

	initial begin
		logic signed [vnrm_pkg::COMP_W-1:0] d [][4];
		int k;
		d = '{
			'{16'sh0, 16'sh0, 16'sh0, 16'sh0},
			'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
			'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
			'{16'sh8000, 16'sh0, 16'sh0, 16'sh0},
			'{16'sh0, 16'sh7fff, 16'sh0, 16'sh0},
			'{16'sh0, 16'sh0, 16'sh8000, 16'sh0},
			'{16'sh0, 16'sh0, 16'sh0, 16'sh7fff},
			'{16'sh1, 16'sh0, 16'sh0, 16'sh0},
			'{16'sh0, 16'shffff, 16'sh0, 16'sh0},
			'{16'sh1, 16'sh1, 16'sh1, 16'sh1},
			'{16'sh7fff, 16'sh8000, 16'sh1, 16'shffff},
			'{16'sh0100, 16'sh0, 16'sh0, 16'sh0},
			'{16'sh0300, 16'sh0400, 16'sh0, 16'sh0},
			'{16'sh0, 16'sh0, 16'shfd00, 16'shfc00},
			'{16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (d[i]) send_vector(d[i][0], d[i][1], d[i][2], d[i][3], 0);
		for (int n = 0; n < 1450; n++) begin
			k = $urandom_range(9);
			if (k < 5) k = 0;
			else if (k < 7) k = 1;
			else if (k < 8) k = 2;
			else k = $urandom_range(3);
			send_vector(pick_comp(k), pick_comp($urandom_range(1) ? k : 3),
				pick_comp(k), pick_comp($urandom_range(3) == 0 ? 3 : k),
				sent >= 600 && sent < 900);
		end
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule

@@ vec4_normalize_core.f @@
+incdir+rtl
rtl/vnrm_pkg.sv
rtl/vnrm_div_cell.sv
rtl/vnrm_sqrt_cell.sv
rtl/vec4_normalize_core.sv
tb/sv/tb_vec4_normalize_core.sv
